// ----- hdl/string_to_u64_parser_macros.svh -----
// assertion macros used by the string_to_u64_parser rtl (s2u_back)
// expects clk and rst_n in the scope of the module that uses them
`ifndef STRING_TO_U64_PARSER_MACROS_SVH
`define STRING_TO_U64_PARSER_MACROS_SVH

// property must hold at every edge outside reset
`define S2U_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define S2U_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/s2u_pkg.sv -----
// shared types and constants for the string_to_u64_parser
// no dependencies
package s2u_pkg;

    localparam int CHAR_W        = 8;
    localparam int VALUE_W       = 64;
    localparam int DIGIT_W       = 4;
    localparam int DEF_CMD_DEPTH = 2;
    localparam int DEF_RES_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        K_SPACE,
        K_PLUS,
        K_MINUS,
        K_X,
        K_DIGIT,
        K_OTHER,
        K_END
    } kind_t;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [DIGIT_W-1:0] digit;
        logic               hex;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

// ----- hdl/string_to_u64_parser.sv -----
// top level of the streaming text to unsigned 64-bit parser
// depends on s2u_pkg, s2u_fifo, s2u_front and s2u_back
//
// One character beat per cycle is accepted while the command queue is not
// full; an end beat closes each string and produces one result beat
// (status and value). The front classifies each character with the base
// latched from hex_mode on cfg_valid, into a short queue; the back walks the
// parse phases and updates the accumulator with a combinational shift-add
// (x10 or x16 plus digit), which sets the one-beat-per-cycle figure. The
// back pops an end beat and pushes its result only while the result queue
// is not full. Write hex_mode only while no string is in flight.
module string_to_u64_parser
    import s2u_pkg::*;
#(
    parameter int CMD_DEPTH = DEF_CMD_DEPTH,
    parameter int RES_DEPTH = DEF_RES_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               hex_mode,
    input  logic               push,
    output logic               full,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               is_end,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         status,
    output logic [VALUE_W-1:0] value
);

    item_t   front_item;
    item_t   cmd_item;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_full;
    logic    res_push;
    result_t res_wdata;
    result_t res_rdata;

    s2u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .hex_mode  (hex_mode),
        .char_code (char_code),
        .is_end    (is_end),
        .item      (front_item)
    );

    s2u_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_item),
        .empty (cmd_empty)
    );

    s2u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_item  (cmd_item),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    s2u_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign status = res_rdata.status;
    assign value  = res_rdata.value;

endmodule

// ----- hdl/s2u_fifo.sv -----
// small register queue used between front and back and on the result side
// no package dependencies
module s2u_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/s2u_front.sv -----
// front end: holds the base register and classifies each incoming character
// depends on s2u_pkg
module s2u_front
    import s2u_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              hex_mode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              is_end,
    output item_t             item
);

    logic hex_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            hex_reg <= hex_mode;
        end
    end

    always_comb
    begin
        item.hex   = hex_reg;
        item.digit = char_code[DIGIT_W-1:0];
        if (is_end)
        begin
            item.kind = K_END;
        end
        else if (char_code == CH_SPACE || char_code inside {[CH_TAB:CH_CR]})
        begin
            item.kind = K_SPACE;
        end
        else if (char_code == CH_PLUS)
        begin
            item.kind = K_PLUS;
        end
        else if (char_code == CH_MINUS)
        begin
            item.kind = K_MINUS;
        end
        else if (char_code inside {[CH_0:CH_9]})
        begin
            item.kind = K_DIGIT;
        end
        else if (hex_reg && (char_code inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}))
        begin
            // letters a..f sit at low nibble 1..6
            item.kind  = K_DIGIT;
            item.digit = char_code[DIGIT_W-1:0] + 4'd9;
        end
        else if (hex_reg && (char_code == CH_LX || char_code == CH_UX))
        begin
            item.kind = K_X;
        end
        else
        begin
            item.kind = K_OTHER;
        end
    end

endmodule

// ----- hdl/s2u_back.sv -----
// back end: parse state machine, accumulator and end-of-string result
// depends on s2u_pkg and the assertion macros
`include "string_to_u64_parser_macros.svh"

module s2u_back
    import s2u_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_empty,
    input  item_t   cmd_item,
    output logic    cmd_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res_data
);

    phase_t               phase_reg, phase_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic                 ovf_reg, ovf_next;
    logic                 neg_reg, neg_next;
    logic [VALUE_W+3:0]   scaled;
    logic [VALUE_W+3:0]   digit_sum;
    logic                 is_end_item;
    logic                 hex_zero;
    logic                 takes_digit;

    assign is_end_item = (cmd_item.kind == K_END);
    assign cmd_pop     = !cmd_empty && (!is_end_item || !res_full);
    assign res_push    = cmd_pop && is_end_item;
    // a leading zero in hex may still open a 0x prefix
    assign hex_zero    = cmd_item.hex && (cmd_item.digit == '0);

    // acc * base + digit, carry bits above 64 flag overflow
    always_comb
    begin
        if (cmd_item.hex)
        begin
            scaled = {acc_reg, 4'b0000};
        end
        else
        begin
            scaled = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1);
        end
        digit_sum = scaled + {{VALUE_W{1'b0}}, cmd_item.digit};
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (cmd_pop)
        begin
            if (is_end_item)
            begin
                phase_next = PH_SPACE;
            end
            else
            begin
                case (phase_reg)
                    PH_SPACE, PH_SIGN:
                    begin
                        if (phase_reg == PH_SPACE && cmd_item.kind == K_SPACE)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (phase_reg == PH_SPACE
                                 && (cmd_item.kind == K_PLUS || cmd_item.kind == K_MINUS))
                        begin
                            phase_next = PH_SIGN;
                        end
                        else if (cmd_item.kind == K_DIGIT)
                        begin
                            phase_next = hex_zero ? PH_ZERO : PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (cmd_item.kind == K_X)
                        begin
                            phase_next = PH_PREFIX;
                        end
                        else if (cmd_item.kind == K_DIGIT)
                        begin
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_PREFIX, PH_DIGITS:
                    begin
                        phase_next = (cmd_item.kind == K_DIGIT) ? PH_DIGITS : PH_ERROR;
                    end
                    default:
                    begin
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end
    end

    // datapath and result
    always_comb
    begin
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        neg_next    = neg_reg;
        takes_digit = 1'b0;

        case (phase_reg)
            PH_SPACE, PH_SIGN: takes_digit = (cmd_item.kind == K_DIGIT) && !hex_zero;
            PH_ZERO, PH_PREFIX, PH_DIGITS: takes_digit = (cmd_item.kind == K_DIGIT);
            default: takes_digit = 1'b0;
        endcase

        if (cmd_pop)
        begin
            if (is_end_item)
            begin
                acc_next = '0;
                ovf_next = 1'b0;
                neg_next = 1'b0;
            end
            else if (takes_digit)
            begin
                acc_next = digit_sum[VALUE_W-1:0];
                ovf_next = ovf_reg || (digit_sum[VALUE_W+3:VALUE_W] != '0);
            end
            else if (phase_reg == PH_SPACE
                     && (cmd_item.kind == K_PLUS || cmd_item.kind == K_MINUS))
            begin
                neg_next = (cmd_item.kind == K_MINUS);
            end
        end

        res_data.value = '0;
        if (ovf_reg)
        begin
            res_data.status = ST_RANGE;
        end
        else if (phase_reg != PH_ZERO && phase_reg != PH_DIGITS)
        begin
            res_data.status = ST_INVAL;
        end
        else if (neg_reg && acc_reg != '0)
        begin
            res_data.status = ST_RANGE;
        end
        else
        begin
            res_data.status = ST_OK;
            res_data.value  = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            neg_reg   <= neg_next;
        end
    end

    `S2U_ASSERT(a_error_sticky, (phase_reg == PH_ERROR && !res_push) |=> (phase_reg == PH_ERROR), "error phase left without end beat")
    `S2U_ASSERT(a_ovf_sticky, (ovf_reg && !res_push) |=> ovf_reg, "overflow flag dropped mid string")
    `S2U_ASSERT(a_end_clears, res_push |=> (phase_reg == PH_SPACE && acc_reg == '0 && !ovf_reg && !neg_reg), "parse state not cleared after end beat")
    `S2U_ASSERT_NEVER(a_no_value_on_error, res_push && res_data.status != ST_OK && res_data.value != '0, "nonzero value with error status")

endmodule
